@@ hw/rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared types and fixed constants for the box suppression unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    // Width of the overlap threshold register, in percent.
    localparam int THR_W = 7;

    // Threshold value after reset, in percent.
    localparam logic [THR_W-1:0] THR_RESET = 7'd45;

    // Scale of the intersection side of the overlap test.
    localparam logic [THR_W-1:0] PERCENT_SCALE = 7'd100;

    // Width of the per-frame box position.
    localparam int FRAME_W = 16;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } gbs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic scan;
        logic commit;
    } gbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } gbs_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Storage array and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gbs_datapath.sv @@
// ----------------------------------------------------------------------------
// Box suppression datapath
// Holds the current box, the kept-box store, the frame counters, the
// four-stage overlap test pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_datapath #(
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration
    input  wire logic                             cfg_write_en,
    input  wire logic [gbs_pkg::THR_W-1:0]        cfg_write_data,
    // Request payload
    input  wire logic                             first_of_frame,
    input  wire logic [COORD_BITS-1:0]            box_left,
    input  wire logic [COORD_BITS-1:0]            box_top,
    input  wire logic [COORD_BITS-1:0]            box_width,
    input  wire logic [COORD_BITS-1:0]            box_height,
    // Result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  keep,
    output logic [gbs_pkg::FRAME_W-1:0]           box_index,
    output logic [$clog2(MAX_KEPT+1)-1:0]         kept_total,
    output logic                                  store_overflow,
    // Controller interface
    input  wire gbs_pkg::gbs_cmd_t                cmd,
    output gbs_pkg::gbs_status_t                  status
);

    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int AREA_W  = 2 * COORD_BITS;
    localparam int UNI_W   = AREA_W + 1;
    localparam int LHS_W   = AREA_W + gbs_pkg::THR_W;
    localparam int RHS_W   = UNI_W + gbs_pkg::THR_W;
    localparam int ENTRY_W = 4 * EDGE_W + AREA_W;
    localparam int FRAME_W = gbs_pkg::FRAME_W;

    // Entry field offsets inside one store word.
    localparam int OFS_AREA   = 0;
    localparam int OFS_BOTTOM = AREA_W;
    localparam int OFS_RIGHT  = AREA_W + EDGE_W;
    localparam int OFS_TOP    = AREA_W + 2 * EDGE_W;
    localparam int OFS_LEFT   = AREA_W + 3 * EDGE_W;

    // Control state.
    logic [gbs_pkg::THR_W-1:0] thr_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [FRAME_W-1:0]        frame_cnt_reg;
    logic [CNT_W-1:0]          scan_idx_reg;
    logic                      suppress_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic                      out_valid_reg;

    // Current box.
    logic [COORD_BITS-1:0]     left_reg, top_reg, wid_reg, hgt_reg;
    logic [EDGE_W-1:0]         right_reg, bottom_reg;
    logic [AREA_W-1:0]         area_reg;
    logic [FRAME_W-1:0]        index_reg;

    // Pipeline payload.
    logic [COORD_BITS-1:0]     ow_reg, oh_reg;
    logic [AREA_W-1:0]         karea2_reg, karea3_reg;
    logic [AREA_W-1:0]         inter_reg;
    logic [UNI_W-1:0]          uni_reg;
    logic [LHS_W-1:0]          lhs_reg;

    // Result payload.
    logic                      keep_reg;
    logic [FRAME_W-1:0]        box_index_reg;
    logic [CNT_W-1:0]          kept_total_reg;
    logic                      overflow_reg;

    // Store ports and stage signals.
    logic [ENTRY_W-1:0]        rd_data;
    logic [ENTRY_W-1:0]        wr_data;
    logic                      store_full;
    logic                      store_wr;
    logic                      keep_now;
    logic [EDGE_W-1:0]         k_left, k_top, k_right, k_bottom;
    logic [AREA_W-1:0]         k_area;
    logic [EDGE_W-1:0]         lo_x, hi_x, lo_y, hi_y;
    logic [EDGE_W-1:0]         ow_full, oh_full;
    logic [RHS_W-1:0]          rhs;
    logic [CNT_W-1:0]          scan_idx_next;

    assign store_full    = (count_reg == CNT_W'(MAX_KEPT));
    assign keep_now      = !suppress_reg;
    assign store_wr      = cmd.commit && keep_now && !store_full;
    assign scan_idx_next = scan_idx_reg + 1'b1;

    // Kept-box store: one word per box holding edges and area.
    assign wr_data = {EDGE_W'(left_reg), EDGE_W'(top_reg), right_reg, bottom_reg, area_reg};

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.scan),
        .rd_addr (scan_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Stage one: overlap spans against the stored box.
    assign k_left   = rd_data[OFS_LEFT   +: EDGE_W];
    assign k_top    = rd_data[OFS_TOP    +: EDGE_W];
    assign k_right  = rd_data[OFS_RIGHT  +: EDGE_W];
    assign k_bottom = rd_data[OFS_BOTTOM +: EDGE_W];
    assign k_area   = rd_data[OFS_AREA   +: AREA_W];

    always_comb
    begin
        lo_x    = (EDGE_W'(left_reg) > k_left) ? EDGE_W'(left_reg) : k_left;
        hi_x    = (right_reg < k_right) ? right_reg : k_right;
        lo_y    = (EDGE_W'(top_reg) > k_top) ? EDGE_W'(top_reg) : k_top;
        hi_y    = (bottom_reg < k_bottom) ? bottom_reg : k_bottom;
        ow_full = (hi_x > lo_x) ? (hi_x - lo_x) : '0;
        oh_full = (hi_y > lo_y) ? (hi_y - lo_y) : '0;
    end

    // Stage four: threshold side of the test.
    assign rhs = RHS_W'(uni_reg) * RHS_W'(thr_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= gbs_pkg::THR_RESET;
            count_reg     <= '0;
            frame_cnt_reg <= '0;
            scan_idx_reg  <= '0;
            suppress_reg  <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thr_reg <= cfg_write_data;
            end

            // A first box clears the frame before it is handled.
            if (cmd.load && first_of_frame)
            begin
                count_reg     <= '0;
                frame_cnt_reg <= '0;
            end

            // Setup takes the box position and starts a fresh scan.
            if (cmd.setup)
            begin
                if (frame_cnt_reg != '1)
                begin
                    frame_cnt_reg <= frame_cnt_reg + 1'b1;
                end
                scan_idx_reg <= '0;
                suppress_reg <= 1'b0;
            end

            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_next;
            end

            // Pipeline occupancy.
            v1_reg <= cmd.scan;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            // Any stored box with too much overlap drops the new box.
            if (v4_reg && (RHS_W'(lhs_reg) > rhs))
            begin
                suppress_reg <= 1'b1;
            end

            if (store_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end

            // Result register handshake.
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg <= box_left;
            top_reg  <= box_top;
            wid_reg  <= box_width;
            hgt_reg  <= box_height;
        end

        if (cmd.setup)
        begin
            right_reg  <= EDGE_W'(left_reg) + EDGE_W'(wid_reg);
            bottom_reg <= EDGE_W'(top_reg) + EDGE_W'(hgt_reg);
            area_reg   <= AREA_W'(wid_reg) * AREA_W'(hgt_reg);
            index_reg  <= frame_cnt_reg;
        end

        // Overlap of one span never exceeds the box size, so it fits.
        ow_reg     <= ow_full[COORD_BITS-1:0];
        oh_reg     <= oh_full[COORD_BITS-1:0];
        karea2_reg <= k_area;

        inter_reg  <= AREA_W'(ow_reg) * AREA_W'(oh_reg);
        karea3_reg <= karea2_reg;

        uni_reg    <= UNI_W'(area_reg) + UNI_W'(karea3_reg) - UNI_W'(inter_reg);
        lhs_reg    <= LHS_W'(inter_reg) * LHS_W'(gbs_pkg::PERCENT_SCALE);

        if (cmd.commit)
        begin
            keep_reg       <= keep_now;
            box_index_reg  <= index_reg;
            kept_total_reg <= store_wr ? (count_reg + 1'b1) : count_reg;
            overflow_reg   <= keep_now && store_full;
        end
    end

    // Status toward the controller.
    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = (scan_idx_next == count_reg);
    assign status.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Result outputs.
    assign out_valid      = out_valid_reg;
    assign keep           = keep_reg;
    assign box_index      = box_index_reg;
    assign kept_total     = kept_total_reg;
    assign store_overflow = overflow_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gbs_controller.sv @@
// ----------------------------------------------------------------------------
// Box suppression controller
// Sequences load, setup, store scan, pipeline drain and the keep decision.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gbs_pkg::gbs_status_t status,
    output gbs_pkg::gbs_cmd_t         cmd
);

    gbs_pkg::gbs_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gbs_pkg::ST_SETUP;
                end
            end
            gbs_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.count_zero ? gbs_pkg::ST_DECIDE : gbs_pkg::ST_SCAN;
            end
            gbs_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = gbs_pkg::ST_DRAIN;
                end
            end
            gbs_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = gbs_pkg::ST_DECIDE;
                end
            end
            gbs_pkg::ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/greedy_box_suppression_unit.sv @@
// ----------------------------------------------------------------------------
// Greedy box suppression unit
// Intersection-over-union suppression of score-sorted detection boxes.
// ----------------------------------------------------------------------------
// Boxes of a frame arrive in falling score order, one request at a time; each
// is compared with every box stored so far in the frame and is dropped when
// inter*100 > threshold*union for any of them. One box is handled at a time:
// the store's single read port feeds one kept box per cycle into a four-stage
// overlap pipeline, and the scan is skipped when nothing is kept yet; the scan,
// drain and keep decision finish before the next request is taken. The input
// is ready again in the same cycle as the result reaches the output register.
// A finished result waits in that output register, so the next request is
// taken while it is still pending; a second result stalls until the first
// is taken. The kept store needs no clearing after reset; only entries below
// the kept count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression_unit #(
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration
    input  wire logic                             cfg_write_en,
    input  wire logic [gbs_pkg::THR_W-1:0]        cfg_write_data,
    // Request channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             first_of_frame,
    input  wire logic [COORD_BITS-1:0]            box_left,
    input  wire logic [COORD_BITS-1:0]            box_top,
    input  wire logic [COORD_BITS-1:0]            box_width,
    input  wire logic [COORD_BITS-1:0]            box_height,
    // Result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  keep,
    output logic [gbs_pkg::FRAME_W-1:0]           box_index,
    output logic [$clog2(MAX_KEPT+1)-1:0]         kept_total,
    output logic                                  store_overflow
);

    gbs_pkg::gbs_cmd_t    cmd;
    gbs_pkg::gbs_status_t status;

    // Sequencing.
    gbs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    gbs_datapath #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .first_of_frame (first_of_frame),
        .box_left       (box_left),
        .box_top        (box_top),
        .box_width      (box_width),
        .box_height     (box_height),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keep           (keep),
        .box_index      (box_index),
        .kept_total     (kept_total),
        .store_overflow (store_overflow),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Greedy box suppression unit testbench
// Sends score-sorted detection boxes through the unit and checks each verdict
// against a behavioral copy of the overlap test, under random idling on both
// channels, several thresholds, a full kept list and a long stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int KEPT_DEPTH  = 64;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    // Behavioral copy of the kept list and the verdicts it leads to.
    class kept_box_ledger;
        logic [gbs_pkg::THR_W-1:0] threshold;
        logic [16:0]               left_edges[KEPT_DEPTH];
        logic [16:0]               top_edges[KEPT_DEPTH];
        logic [16:0]               right_edges[KEPT_DEPTH];
        logic [16:0]               bottom_edges[KEPT_DEPTH];
        logic [31:0]               areas[KEPT_DEPTH];
        int unsigned               kept_cnt;
        logic [15:0]               box_cnt;
        logic [24:0]               pending_verdicts[$];
        int unsigned               errors;

        function new();
            threshold = gbs_pkg::THR_RESET;
            kept_cnt  = 0;
            box_cnt   = '0;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return pending_verdicts.size();
        endfunction

        function longint unsigned shared_span(logic [16:0] lo_a, hi_a, lo_b, hi_b);
            logic [16:0] lo;
            logic [16:0] hi;
            lo = (lo_a > lo_b) ? lo_a : lo_b;
            hi = (hi_a < hi_b) ? hi_a : hi_b;
            return (hi > lo) ? 64'(hi - lo) : 64'd0;
        endfunction

        // Work out the verdict of one accepted request and queue it.
        function void take_box(input logic first, input logic [15:0] l, t, w, h);
            logic [16:0]     r;
            logic [16:0]     b;
            logic [31:0]     a;
            logic [15:0]     index;
            longint unsigned inter;
            longint unsigned uni;
            logic            survives;
            logic            overflow;
            logic [24:0]     verdict;
            r = l + w;
            b = t + h;
            a = w * h;
            if (first)
            begin
                kept_cnt = 0;
                box_cnt  = '0;
            end
            index = box_cnt;
            if (box_cnt != 16'hFFFF)
                box_cnt++;
            survives = 1'b1;
            overflow = 1'b0;
            for (int k = 0; k < kept_cnt; k++)
            begin
                inter = shared_span(17'(l), r, left_edges[k], right_edges[k])
                        * shared_span(17'(t), b, top_edges[k], bottom_edges[k]);
                uni = a + areas[k] - inter;
                if (inter * gbs_pkg::PERCENT_SCALE > threshold * uni)
                    survives = 1'b0;
            end
            if (survives)
            begin
                if (kept_cnt < KEPT_DEPTH)
                begin
                    left_edges[kept_cnt]   = 17'(l);
                    top_edges[kept_cnt]    = 17'(t);
                    right_edges[kept_cnt]  = r;
                    bottom_edges[kept_cnt] = b;
                    areas[kept_cnt]        = a;
                    kept_cnt++;
                end
                else
                    overflow = 1'b1;
            end
            verdict = {survives, index, 7'(kept_cnt), overflow};
            pending_verdicts = {pending_verdicts, verdict};
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest verdict waiting.
        function void match_verdict(logic got_keep, logic [15:0] got_index,
                                    logic [6:0] got_total, logic got_overflow);
            logic [24:0] want;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending", $time);
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("keep", 16'(want[24]), 16'(got_keep));
            compare_field("box_index", want[23:8], got_index);
            compare_field("kept_total", 16'(want[7:1]), 16'(got_total));
            compare_field("store_overflow", 16'(want[0]), 16'(got_overflow));
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [gbs_pkg::THR_W-1:0] cfg_write_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      first_of_frame = 1'b0;
    logic [15:0]               box_left = '0;
    logic [15:0]               box_top = '0;
    logic [15:0]               box_width = '0;
    logic [15:0]               box_height = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      keep;
    logic [15:0]               box_index;
    logic [6:0]                kept_total;
    logic                      store_overflow;

    kept_box_ledger ledger = new();

    int unsigned tx_idle_pct = 28;
    int unsigned rx_idle_pct = 57;
    int unsigned hold_armed = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned boxes_sent = 0;

    greedy_box_suppression_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_of_frame (first_of_frame),
        .box_left       (box_left),
        .box_top        (box_top),
        .box_width      (box_width),
        .box_height     (box_height),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keep           (keep),
        .box_index      (box_index),
        .kept_total     (kept_total),
        .store_overflow (store_overflow)
    );

    // Clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check accepted results, then pick the next ready level.
    // A pending hold request keeps ready low for a long stretch.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            ledger.match_verdict(keep, box_index, kept_total, store_overflow);
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_armed)
        begin
            hold_seen <= hold_armed;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one box, with a random gap first, and wait until it is taken.
    task automatic send_box(input logic first, input logic [15:0] l, t, w, h);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid       <= 1'b1;
        first_of_frame <= first;
        box_left       <= l;
        box_top        <= t;
        box_width      <= w;
        box_height     <= h;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.take_box(first, l, t, w, h);
        boxes_sent++;
    endtask

    // Stop offering and wait until every verdict has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [gbs_pkg::THR_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en     <= 1'b0;
        ledger.threshold = value;
    endtask

    // A frame of boxes scattered around a few centers, so that many overlap.
    task automatic send_cluster_frame();
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] size_x;
        logic [15:0] size_y;
        logic [15:0] w;
        logic [15:0] h;
        int          len;
        int          j;
        len = $urandom_range(2, 24);
        for (j = 0; j < len; j++)
        begin
            if (j == 0 || $urandom_range(3) == 0)
            begin
                cx     = 16'($urandom_range(60000));
                cy     = 16'($urandom_range(60000));
                size_x = 16'($urandom_range(8, 2000));
                size_y = 16'($urandom_range(8, 2000));
            end
            w = 16'(size_x / 2 + $urandom_range(size_x));
            h = 16'(size_y / 2 + $urandom_range(size_y));
            if ($urandom_range(15) == 0)
                w = '0;
            if ($urandom_range(15) == 0)
                h = '0;
            send_box((j == 0) ? ($urandom_range(7) != 0) : 1'b0,
                     16'(cx + $urandom_range(size_x / 4)),
                     16'(cy + $urandom_range(size_y / 4)), w, h);
        end
    endtask

    // Short frame of boxes with every field drawn over its whole range.
    task automatic send_noise_frame();
        int len;
        int j;
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++)
            send_box(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                     16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                     16'($urandom_range(16'hFFFF)));
    endtask

    // Disjoint boxes until the kept list is full, then more disjoint boxes
    // (kept but not stored) mixed with repeats of the first box.
    task automatic send_full_frame();
        logic [15:0] bx;
        logic [15:0] by;
        int          len;
        int          j;
        bx  = 16'($urandom_range(40000));
        by  = 16'($urandom_range(60000));
        len = $urandom_range(66, 74);
        for (j = 0; j < len; j++)
        begin
            if (j >= KEPT_DEPTH && $urandom_range(2) == 0)
                send_box(1'b0, bx, by, 16'd128, 16'd128);
            else
                send_box(j == 0, 16'(bx + j * 256), by, 16'd128,
                         16'(128 + $urandom_range(60)));
        end
    endtask

    // One phase: settle, set the threshold and idling, then an optional full frame and random frames.
    task automatic run_phase(input logic [gbs_pkg::THR_W-1:0] thr, input int unsigned tx_pct,
                             input int unsigned rx_pct, input int unsigned items,
                             input bit fill_store, input bit long_hold);
        int unsigned start;
        wait_drain();
        repeat (4) @(posedge clk);
        write_threshold(thr);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (long_hold)
            hold_armed <= hold_armed + 1;
        start = boxes_sent;
        if (fill_store)
            send_full_frame();
        while (boxes_sent - start < items)
        begin
            if ($urandom_range(9) == 0)
                send_noise_frame();
            else
                send_cluster_frame();
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [gbs_pkg::THR_W-1:0] mid_thr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed boxes at the reset threshold; the first one carries no
        // frame flag and so continues the frame that reset left open.
        send_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd16);
        send_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd16);
        send_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_box(1'b0, 16'd16, 16'd0, 16'd16, 16'd16);
        send_box(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(1'b0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_box(1'b1, 16'd0, 16'd0, 16'd100, 16'd100);
        send_box(1'b0, 16'd10, 16'd0, 16'd100, 16'd100);
        send_box(1'b0, 16'd55, 16'd0, 16'd100, 16'd100);
        // Overlap ratio exactly at the threshold is not above it.
        send_box(1'b1, 16'd1000, 16'd1000, 16'd20, 16'd1);
        send_box(1'b0, 16'd1005, 16'd1000, 16'd9, 16'd1);
        send_box(1'b0, 16'd1005, 16'd1000, 16'd10, 16'd1);
        send_box(1'b1, 16'h5555, 16'hAAAA, 16'h00FF, 16'h0F0F);

        // Random phases over thresholds and idling patterns.
        run_phase(7'd0, 28, 57, 150, 1'b1, 1'b0);
        run_phase(7'd50, 28, 57, 150, 1'b0, 1'b0);
        run_phase(7'd127, 57, 28, 150, 1'b1, 1'b0);
        run_phase(7'd100, 57, 28, 150, 1'b0, 1'b0);
        mid_thr = 7'($urandom_range(1, 99));
        run_phase(mid_thr, 0, 0, 300, 1'b1, 1'b1);

        wait_drain();
        repeat (100) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
